/* rtl/core/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define BFFLA_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define BFFLA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`define BFFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/bffla_pkg.sv */
// Package for the best-fit free-list allocator: sizes, codes and the
// command and status structures between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bffla_pkg;
	localparam int MAX_AREAS = 64;
	localparam int ADDR_BITS = 16;
	localparam int SIZE_W    = 16;
	localparam int IDX_W     = $clog2(MAX_AREAS + 1);
	localparam int AW        = $clog2(MAX_AREAS);

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FULL  = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_FREE    = 2'd1,
		MODE_RECLAIM = 2'd2,
		MODE_BAD     = 2'd3
	} mode_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_RD_K,
		OP_INC_K,
		OP_FOUND,
		OP_RD_JP1,
		OP_MOVE_UP,
		OP_DEC_COUNT,
		OP_ALLOC_POST,
		OP_FREE_LOAD,
		OP_INS_POS,
		OP_RD_JM1,
		OP_MOVE_DN,
		OP_PUT_INC_COUNT,
		OP_SORT_INIT_ADDR,
		OP_SORT_INIT_SIZE,
		OP_RD_I,
		OP_SORT_LD,
		OP_SORT_PUT,
		OP_RD_0,
		OP_MRG_LD,
		OP_MRG_JOIN,
		OP_MRG_SKIP
	} dp_op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_SCAN_W,
		S_REM,
		S_REM_W,
		S_ALLOC_POST,
		S_INS,
		S_INS_W,
		S_SHR,
		S_SHR_W,
		S_SORT_I,
		S_SORT_LD,
		S_SORT_J,
		S_SORT_C,
		S_MRG_LD,
		S_MRG_K,
		S_MRG_C,
		S_FINISH
	} ctl_state_t;

	typedef struct packed {
		dp_op_t  op;
		logic    set_status;
		status_t status_code;
		logic    load_out;
	} dp_cmd_t;

	typedef struct packed {
		mode_t            mode;
		logic [IDX_W-1:0] count;
		logic             bad_alloc;
		logic             bad_free;
		logic             full;
		logic             count_zero;
		logic             k_end;
		logic             fit;
		logic             ins_here;
		logic             rem_end;
		logic             j_zero;
		logic             j_at_pos;
		logic             i_end;
		logic             after;
		logic             join_ok;
		logic             need_rem;
		logic             by_addr;
		logic             out_free;
	} dp_stat_t;
endpackage
`default_nettype wire

/* rtl/core/bffla_req_if.sv */
// Request channel interface of the allocator.
// Depends on nothing; the field widths follow the request format.
`timescale 1ns / 1ps
`default_nettype none
interface bffla_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [15:0] req_size;
	logic [15:0] req_base;

	modport source (output valid, output mode, output req_size, output req_base, input ready);
	modport sink (input valid, input mode, input req_size, input req_base, output ready);
endinterface
`default_nettype wire

/* rtl/core/bffla_rsp_if.sv */
// Response channel interface of the allocator.
// Depends on nothing; the field widths follow the response format.
`timescale 1ns / 1ps
`default_nettype none
interface bffla_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] out_base;
	logic [15:0] out_size;
	logic [6:0]  merges;

	modport source (output valid, output status, output out_base, output out_size,
		output merges, input ready);
	modport sink (input valid, input status, input out_base, input out_size,
		input merges, output ready);
endinterface
`default_nettype wire

/* rtl/core/bffla_ctrl.sv */
// Controller state machine of the allocator: sequences table walks and shifts.
// Depends on bffla_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bffla_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  bffla_pkg::dp_stat_t stat,
	output bffla_pkg::dp_cmd_t  cmd
);
	import bffla_pkg::*;

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				unique case (stat.mode)
					MODE_ALLOC: state_d = stat.bad_alloc ? S_FINISH : S_SCAN;
					MODE_FREE: state_d = (stat.bad_free || stat.full) ? S_FINISH : S_INS;
					MODE_RECLAIM: state_d = stat.count_zero ? S_FINISH : S_SORT_I;
					default: state_d = S_FINISH;
				endcase
			end
			S_SCAN: state_d = stat.k_end ? S_FINISH : S_SCAN_W;
			S_SCAN_W: state_d = stat.fit ? S_REM : S_SCAN;
			S_REM: begin
				if (!stat.rem_end) state_d = S_REM_W;
				else if (stat.mode == MODE_ALLOC) state_d = S_ALLOC_POST;
				else state_d = S_MRG_K;
			end
			S_REM_W: state_d = S_REM;
			S_ALLOC_POST: state_d = stat.need_rem ? S_INS : S_FINISH;
			S_INS: state_d = stat.k_end ? S_SHR : S_INS_W;
			S_INS_W: state_d = stat.ins_here ? S_SHR : S_INS;
			S_SHR: state_d = stat.j_at_pos ? S_FINISH : S_SHR_W;
			S_SHR_W: state_d = S_SHR;
			S_SORT_I: begin
				if (!stat.i_end) state_d = S_SORT_LD;
				else if (stat.by_addr) state_d = S_MRG_LD;
				else state_d = S_FINISH;
			end
			S_SORT_LD: state_d = S_SORT_J;
			S_SORT_J: state_d = stat.j_zero ? S_SORT_I : S_SORT_C;
			S_SORT_C: state_d = stat.after ? S_SORT_J : S_SORT_I;
			S_MRG_LD: state_d = S_MRG_K;
			S_MRG_K: state_d = stat.k_end ? S_SORT_I : S_MRG_C;
			S_MRG_C: state_d = stat.join_ok ? S_REM : S_MRG_K;
			S_FINISH: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		cmd.op          = OP_NONE;
		cmd.set_status  = 1'b0;
		cmd.status_code = ST_OK;
		cmd.load_out    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_ACCEPT;
			end
			S_DISPATCH: begin
				unique case (stat.mode)
					MODE_ALLOC: begin
						cmd.set_status  = 1'b1;
						cmd.status_code = stat.bad_alloc ? ST_BAD : ST_NOFIT;
					end
					MODE_FREE: begin
						if (stat.bad_free) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_BAD;
						end else if (stat.full) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_FULL;
						end else begin
							cmd.op = OP_FREE_LOAD;
						end
					end
					MODE_RECLAIM: begin
						if (!stat.count_zero) cmd.op = OP_SORT_INIT_ADDR;
					end
					default: begin
						cmd.set_status  = 1'b1;
						cmd.status_code = ST_BAD;
					end
				endcase
			end
			S_SCAN: begin
				if (!stat.k_end) cmd.op = OP_RD_K;
			end
			S_SCAN_W: begin
				if (stat.fit) begin
					cmd.op          = OP_FOUND;
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_OK;
				end else begin
					cmd.op = OP_INC_K;
				end
			end
			S_REM: cmd.op = stat.rem_end ? OP_DEC_COUNT : OP_RD_JP1;
			S_REM_W: cmd.op = OP_MOVE_UP;
			S_ALLOC_POST: cmd.op = OP_ALLOC_POST;
			S_INS: cmd.op = stat.k_end ? OP_INS_POS : OP_RD_K;
			S_INS_W: cmd.op = stat.ins_here ? OP_INS_POS : OP_INC_K;
			S_SHR: cmd.op = stat.j_at_pos ? OP_PUT_INC_COUNT : OP_RD_JM1;
			S_SHR_W: cmd.op = OP_MOVE_DN;
			S_SORT_I: begin
				if (!stat.i_end) cmd.op = OP_RD_I;
				else if (stat.by_addr) cmd.op = OP_RD_0;
			end
			S_SORT_LD: cmd.op = OP_SORT_LD;
			S_SORT_J: cmd.op = stat.j_zero ? OP_SORT_PUT : OP_RD_JM1;
			S_SORT_C: cmd.op = stat.after ? OP_MOVE_DN : OP_SORT_PUT;
			S_MRG_LD: cmd.op = OP_MRG_LD;
			S_MRG_K: cmd.op = stat.k_end ? OP_SORT_INIT_SIZE : OP_RD_K;
			S_MRG_C: cmd.op = stat.join_ok ? OP_MRG_JOIN : OP_MRG_SKIP;
			S_FINISH: cmd.load_out = stat.out_free;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/core/bffla_dpath.sv */
// Datapath of the allocator: area table memory, index counters, working
// registers and the response register. Depends on bffla_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bffla_dpath (
	input  wire                              clk,
	input  wire                              arst_n,
	input  bffla_pkg::dp_cmd_t               cmd,
	output bffla_pkg::dp_stat_t              stat,
	input  wire                              cfg_we,
	input  wire  [bffla_pkg::SIZE_W-1:0]     cfg_wdata,
	input  wire  [1:0]                       in_mode,
	input  wire  [bffla_pkg::SIZE_W-1:0]     in_size,
	input  wire  [bffla_pkg::ADDR_BITS-1:0]  in_base,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [1:0]                       out_status,
	output logic [bffla_pkg::ADDR_BITS-1:0]  out_base,
	output logic [bffla_pkg::SIZE_W-1:0]     out_size,
	output logic [bffla_pkg::IDX_W-1:0]      out_merges
);
	import bffla_pkg::*;

	logic [ADDR_BITS-1:0] mem_base [MAX_AREAS];
	logic [SIZE_W-1:0]    mem_size [MAX_AREAS];

	logic [SIZE_W-1:0]    total_q;
	logic [IDX_W-1:0]     count_q;
	logic                 fresh_q;
	logic                 by_addr_q;
	logic [IDX_W-1:0]     i_q, j_q, k_q, c_q;
	logic [1:0]           mode_q;
	logic [SIZE_W-1:0]    rsize_q;
	logic [ADDR_BITS-1:0] rbase_q;
	logic [ADDR_BITS-1:0] hb_q, cb_q, rb_q, res_base_q;
	logic [SIZE_W-1:0]    hs_q, cs_q, rs_q, res_size_q;
	status_t              res_status_q;
	logic [IDX_W-1:0]     joins_q;
	logic                 out_valid_q;

	logic                 re, we;
	logic [AW-1:0]        raddr, waddr;
	logic [ADDR_BITS-1:0] wb;
	logic [SIZE_W-1:0]    ws;
	logic [IDX_W-1:0]     j_p1, j_m1;
	logic [SIZE_W:0]      join_sum;
	logic [ADDR_BITS:0]   cur_end;

	assign j_p1     = j_q + 1'b1;
	assign j_m1     = j_q - 1'b1;
	assign join_sum = {1'b0, cs_q} + {1'b0, rs_q};
	assign cur_end  = {1'b0, cb_q} + {{(ADDR_BITS + 1 - SIZE_W){1'b0}}, cs_q};

	always_comb begin
		re    = 1'b0;
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wb    = '0;
		ws    = '0;
		unique case (cmd.op)
			OP_RD_K: begin
				re    = 1'b1;
				raddr = k_q[AW-1:0];
			end
			OP_RD_JP1: begin
				re    = 1'b1;
				raddr = j_p1[AW-1:0];
			end
			OP_RD_JM1: begin
				re    = 1'b1;
				raddr = j_m1[AW-1:0];
			end
			OP_RD_I: begin
				re    = 1'b1;
				raddr = i_q[AW-1:0];
			end
			OP_RD_0: begin
				re    = 1'b1;
				raddr = '0;
			end
			OP_MOVE_UP, OP_MOVE_DN: begin
				we    = 1'b1;
				waddr = j_q[AW-1:0];
				wb    = rb_q;
				ws    = rs_q;
			end
			OP_PUT_INC_COUNT, OP_SORT_PUT: begin
				we    = 1'b1;
				waddr = j_q[AW-1:0];
				wb    = hb_q;
				ws    = hs_q;
			end
			OP_MRG_JOIN: begin
				we    = 1'b1;
				waddr = c_q[AW-1:0];
				wb    = cb_q;
				ws    = join_sum[SIZE_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cfg_we) begin
			mem_base[0] <= '0;
			mem_size[0] <= cfg_wdata;
		end else if (we) begin
			mem_base[waddr] <= wb;
			mem_size[waddr] <= ws;
		end
		if (re) begin
			if (fresh_q && raddr == '0) begin
				rb_q <= '0;
				rs_q <= total_q;
			end else begin
				rb_q <= mem_base[raddr];
				rs_q <= mem_size[raddr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '1;
			count_q     <= IDX_W'(1);
			fresh_q     <= 1'b1;
			by_addr_q   <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			c_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we || (we && waddr == '0)) fresh_q <= 1'b0;
			if (cfg_we) begin
				total_q <= cfg_wdata;
				count_q <= (cfg_wdata != '0) ? IDX_W'(1) : '0;
			end
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (cmd.op)
				OP_ACCEPT: k_q <= '0;
				OP_INC_K: k_q <= k_q + 1'b1;
				OP_FOUND: j_q <= k_q;
				OP_MOVE_UP: j_q <= j_p1;
				OP_MOVE_DN: j_q <= j_m1;
				OP_DEC_COUNT: count_q <= count_q - 1'b1;
				OP_ALLOC_POST, OP_FREE_LOAD: k_q <= '0;
				OP_INS_POS: j_q <= count_q;
				OP_PUT_INC_COUNT: count_q <= count_q + 1'b1;
				OP_SORT_INIT_ADDR: begin
					i_q       <= IDX_W'(1);
					by_addr_q <= 1'b1;
				end
				OP_SORT_INIT_SIZE: begin
					i_q       <= IDX_W'(1);
					by_addr_q <= 1'b0;
				end
				OP_SORT_LD: j_q <= i_q;
				OP_SORT_PUT: i_q <= i_q + 1'b1;
				OP_MRG_LD: begin
					c_q <= '0;
					k_q <= IDX_W'(1);
				end
				OP_MRG_JOIN: j_q <= k_q;
				OP_MRG_SKIP: begin
					c_q <= k_q;
					k_q <= k_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_status) res_status_q <= cmd.status_code;
		if (cmd.load_out) begin
			out_status <= res_status_q;
			out_base   <= res_base_q;
			out_size   <= res_size_q;
			out_merges <= joins_q;
		end
		unique case (cmd.op)
			OP_ACCEPT: begin
				mode_q       <= in_mode;
				rsize_q      <= in_size;
				rbase_q      <= in_base;
				res_status_q <= ST_OK;
				res_base_q   <= '0;
				res_size_q   <= '0;
				joins_q      <= '0;
			end
			OP_FOUND, OP_SORT_LD: begin
				hb_q <= rb_q;
				hs_q <= rs_q;
			end
			OP_ALLOC_POST: begin
				res_base_q <= hb_q;
				res_size_q <= rsize_q;
				hb_q       <= hb_q + rsize_q;
				hs_q       <= hs_q - rsize_q;
			end
			OP_FREE_LOAD: begin
				hb_q <= rbase_q;
				hs_q <= rsize_q;
			end
			OP_MRG_LD, OP_MRG_SKIP: begin
				cb_q <= rb_q;
				cs_q <= rs_q;
			end
			OP_MRG_JOIN: begin
				cs_q    <= join_sum[SIZE_W-1:0];
				joins_q <= joins_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	always_comb begin
		stat.mode       = mode_t'(mode_q);
		stat.count      = count_q;
		stat.bad_alloc  = (rsize_q == '0) || (rsize_q > total_q);
		stat.bad_free   = (rsize_q == '0);
		stat.full       = (count_q >= IDX_W'(MAX_AREAS));
		stat.count_zero = (count_q == '0);
		stat.k_end      = (k_q >= count_q);
		stat.fit        = (rsize_q <= rs_q);
		stat.ins_here   = (hs_q < rs_q);
		stat.rem_end    = (j_p1 >= count_q);
		stat.j_zero     = (j_q == '0);
		stat.j_at_pos   = (j_q == k_q);
		stat.i_end      = (i_q >= count_q);
		stat.after      = by_addr_q ? ((rb_q > hb_q) || (rb_q == hb_q && rs_q > hs_q))
			: (rs_q > hs_q);
		stat.join_ok    = ({1'b0, rb_q} == cur_end) && !join_sum[SIZE_W];
		stat.need_rem   = (hs_q > rsize_q);
		stat.by_addr    = by_addr_q;
		stat.out_free   = !out_valid_q || out_ready;
	end
endmodule
`default_nettype wire

/* rtl/core/best_fit_free_list_allocator_top.sv */
// Top level of the best-fit free-list allocator: joins controller and datapath.
// Depends on bffla_pkg, bffla_req_if, bffla_rsp_if, bffla_ctrl, bffla_dpath.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// The block handles one transaction at a time, and each one takes a variable
// time set by the single-port walk over the area table. An allocate scans the
// areas up to the fit, shifts the areas behind it on removal and shifts areas
// again to reinsert a remainder. A free walks the table to its insertion point
// and shifts the areas behind it. A reclaim runs two insertion sorts and a merge
// pass, and costs least when the table is already nearly in order. One result
// transaction follows each request; a finished result waits in the output register
// while the next request is taken. Writing total_size resets the table to one area,
// or to no area when the written size is zero.
module best_fit_free_list_allocator_top (
	input  wire            clk,
	input  wire            arst_n,
	bffla_req_if.sink      req,
	bffla_rsp_if.source    rsp,
	input  wire            cfg_we,
	input  wire  [15:0]    cfg_wdata
);
	import bffla_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     ctl_ready;

	bffla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (ctl_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bffla_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_mode    (req.mode),
		.in_size    (req.req_size),
		.in_base    (req.req_base),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_status (rsp.status),
		.out_base   (rsp.out_base),
		.out_size   (rsp.out_size),
		.out_merges (rsp.merges)
	);

	assign req.ready = ctl_ready;

	`BFFLA_ASSERT_ALWAYS(a_count_bound, stat.count <= IDX_W'(MAX_AREAS), "area count overflow")
	`BFFLA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
	`BFFLA_ASSERT_IMPL(a_merges_ok, rsp.valid && rsp.merges != '0, rsp.status == ST_OK, "merge status")
	`BFFLA_ASSERT_IMPL(a_fail_zero, rsp.valid && rsp.status != ST_OK, rsp.out_base == '0 && rsp.out_size == '0, "failed result not zero")
endmodule
`default_nettype wire
